[rtl/sva_pkg.sv]
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, command codes and constants for the voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  // Default pool geometry.
  localparam int VOICES_DEFAULT   = 24;
  localparam int CHANNELS_DEFAULT = 16;

  // Field widths of the input and result words.
  localparam int CMD_W   = 3;
  localparam int CHAN_W  = 4;
  localparam int NOTE_W  = 7;
  localparam int LEVEL_W = 7;
  localparam int VOICE_W = 5;
  localparam int MASK_W  = 24;
  localparam int COUNT_W = 5;
  localparam int TICK_W  = 32;

  // Scoring and controller constants.
  localparam int HELD_BONUS     = 10000;
  localparam int VEL_WEIGHT     = 10;
  localparam int VEL_TOP        = 127;
  localparam int SUSTAIN_ON     = 64;
  localparam int REVERB_DEFAULT = 40;
  localparam int VEL_TERM_W     = 11;

  // Voice count after reset.
  localparam logic [COUNT_W-1:0] VOICE_COUNT_RESET = 5'd16;

  // Depth of the queue between the decoder and the engine.
  localparam int QUEUE_DEPTH = 2;

  // Raw command codes on the input port.
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUSTAIN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REVERB   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd5;

  // Classified operations handed to the engine.
  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_SUSTAIN,
    OP_REVERB,
    OP_TICK,
    OP_RESTART,
    OP_NOP
  } op_t;

  // One classified word in the queue.
  typedef struct packed {
    op_t                 op;
    logic [CHAN_W-1:0]   channel;
    logic [NOTE_W-1:0]   note;
    logic [NOTE_W-1:0]   velocity;
    logic [LEVEL_W-1:0]  value;
  } cmd_item_t;

  // One result word.
  typedef struct packed {
    logic                voice_valid;
    logic [VOICE_W-1:0]  voice;
    logic                stolen;
    logic [MASK_W-1:0]   key_on_mask;
    logic [MASK_W-1:0]   key_off_mask;
    logic [MASK_W-1:0]   reverb_mask;
  } result_t;

endpackage

[rtl/sva_front.sv]
// ----------------------------------------------------------------------------
// Voice allocator front end
// Accepts input words and classifies them into engine operations.
// ----------------------------------------------------------------------------
module sva_front #(
  parameter int CHANNELS = sva_pkg::CHANNELS_DEFAULT
) (
  input  logic                          push,
  output logic                          full,
  input  logic [sva_pkg::CMD_W-1:0]     in_command,
  input  logic [sva_pkg::CHAN_W-1:0]    in_channel,
  input  logic [sva_pkg::NOTE_W-1:0]    in_note,
  input  logic [sva_pkg::NOTE_W-1:0]    in_velocity,
  input  logic [sva_pkg::LEVEL_W-1:0]   in_value,
  input  logic                          in_tone_valid,
  input  logic                          q_full,
  output logic                          q_wr,
  output sva_pkg::cmd_item_t            q_item
);
  import sva_pkg::*;

  logic chan_ok;

  // A channel command is only honored for channels that exist.
  assign chan_ok = ({1'b0, in_channel} < (CHAN_W+1)'(CHANNELS));

  // Handshake follows the queue occupancy.
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Classify the word; anything that has no effect becomes a no-op.
  always_comb begin
    q_item.channel  = in_channel;
    q_item.note     = in_note;
    q_item.velocity = in_velocity;
    q_item.value    = in_value;
    case (in_command)
      CMD_NOTE_ON:  q_item.op = (chan_ok && in_tone_valid) ? OP_NOTE_ON : OP_NOP;
      CMD_NOTE_OFF: q_item.op = chan_ok ? OP_NOTE_OFF : OP_NOP;
      CMD_SUSTAIN:  q_item.op = chan_ok ? OP_SUSTAIN : OP_NOP;
      CMD_REVERB:   q_item.op = chan_ok ? OP_REVERB : OP_NOP;
      CMD_TICK:     q_item.op = OP_TICK;
      CMD_RESTART:  q_item.op = OP_RESTART;
      default:      q_item.op = OP_NOP;
    endcase
  end

endmodule

[rtl/sva_queue.sv]
// ----------------------------------------------------------------------------
// Voice allocator command queue
// Short queue between the front end and the engine.
// ----------------------------------------------------------------------------
module sva_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  sva_pkg::cmd_item_t  wr_item,
  output logic                q_full,
  input  logic                rd,
  output logic                q_empty,
  output sva_pkg::cmd_item_t  rd_item
);
  import sva_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_item = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/sva_engine.sv]
// ----------------------------------------------------------------------------
// Voice allocator engine
// Holds the voice and channel state and carries out one command at a time.
// ----------------------------------------------------------------------------
module sva_engine #(
  parameter int VOICES   = sva_pkg::VOICES_DEFAULT,
  parameter int CHANNELS = sva_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sva_pkg::COUNT_W-1:0]   voice_count,
  input  logic                          q_empty,
  input  sva_pkg::cmd_item_t            q_item,
  output logic                          q_rd,
  input  logic                          res_pop,
  output logic                          res_valid,
  output sva_pkg::result_t              res
);
  import sva_pkg::*;

  localparam int IW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);
  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_X = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LAST
  } state_t;

  state_t                state_r, state_nxt;
  cmd_item_t             cmd_r, cmd_nxt;
  logic [VOICES-1:0]     active_r, active_nxt;
  logic [VOICES-1:0]     held_r, held_nxt;
  logic [VOICES-1:0]     reverb_r, reverb_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [LEVEL_W-1:0]    sustain_r [CHANNELS];
  logic [LEVEL_W-1:0]    sustain_nxt [CHANNELS];
  logic [LEVEL_W-1:0]    chrev_r [CHANNELS];
  logic [LEVEL_W-1:0]    chrev_nxt [CHANNELS];
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [TICK_W-1:0]     score_r, score_nxt;
  logic [IW-1:0]         sidx_r, sidx_nxt;
  logic                  svld_r, svld_nxt;
  logic [TICK_W-1:0]     best_r, best_nxt;
  logic [IW-1:0]         bidx_r, bidx_nxt;
  logic                  res_valid_r, res_valid_nxt;
  result_t               res_r, res_nxt;

  // Per-voice note data, written on note on only.
  logic [CHAN_W-1:0]     vchan_r [VOICES];
  logic [NOTE_W-1:0]     vnote_r [VOICES];
  logic [NOTE_W-1:0]     vvel_r [VOICES];
  logic [TICK_W-1:0]     vstart_r [VOICES];

  logic [CNT_X-1:0]      count_ext;
  logic [CNT_W-1:0]      n_en;
  logic [VOICES-1:0]     en_mask;
  logic [VOICES-1:0]     free_mask;
  logic                  any_free;
  logic [IW-1:0]         free_idx;
  logic [VOICES-1:0]     off_match;
  logic [VOICES-1:0]     rel_match;
  logic [CH_IW-1:0]      ch_idx;
  logic [LEVEL_W-1:0]    ch_sustain;
  logic [LEVEL_W-1:0]    ch_reverb;
  logic [NOTE_W-1:0]     vel_gap;
  logic [VEL_TERM_W-1:0] vel_term;
  logic [TICK_W-1:0]     score_now;
  logic                  scan_last;
  logic [IW-1:0]         steal_idx;
  logic                  on_we;
  logic [IW-1:0]         on_idx;
  logic                  emit;

  // Clamp the enabled voice count to 1..VOICES and build the enable mask.
  assign count_ext = CNT_X'(voice_count);
  always_comb begin
    if (count_ext == '0) begin
      n_en = CNT_W'(1);
    end else if (count_ext > CNT_X'(VOICES)) begin
      n_en = CNT_W'(VOICES);
    end else begin
      n_en = CNT_W'(count_ext);
    end
    for (int i = 0; i < VOICES; i++) begin
      en_mask[i] = (CNT_W'(i) < n_en);
    end
  end

  // Lowest free enabled voice.
  assign free_mask = ~active_r & en_mask;
  assign any_free  = |free_mask;
  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Channel controller values of the current command.
  assign ch_idx     = cmd_r.channel[CH_IW-1:0];
  assign ch_sustain = sustain_r[ch_idx];
  assign ch_reverb  = chrev_r[ch_idx];

  // Per-voice match lanes for note off and sustain release.
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      off_match[i] = active_r[i] && en_mask[i] && (vchan_r[i] == cmd_r.channel)
                     && (vnote_r[i] == cmd_r.note);
      rel_match[i] = active_r[i] && held_r[i] && en_mask[i]
                     && (vchan_r[i] == cmd_r.channel);
    end
  end

  // Steal score of the voice under the scan index.
  assign vel_gap   = NOTE_W'(VEL_TOP) - vvel_r[idx_r];
  assign vel_term  = VEL_TERM_W'(vel_gap) * VEL_TERM_W'(VEL_WEIGHT);
  assign score_now = tick_r - vstart_r[idx_r]
                     + (held_r[idx_r] ? TICK_W'(HELD_BONUS) : '0)
                     + TICK_W'(vel_term);
  assign scan_last = (CNT_W'(idx_r) == n_en - 1'b1);

  // Winner after the last score is in.
  assign steal_idx = (svld_r && ($signed(score_r) > $signed(best_r))) ? sidx_r : bidx_r;

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    active_nxt    = active_r;
    held_nxt      = held_r;
    reverb_nxt    = reverb_r;
    tick_nxt      = tick_r;
    sustain_nxt   = sustain_r;
    chrev_nxt     = chrev_r;
    idx_nxt       = idx_r;
    score_nxt     = score_r;
    sidx_nxt      = sidx_r;
    svld_nxt      = svld_r;
    best_nxt      = best_r;
    bidx_nxt      = bidx_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    q_rd          = 1'b0;
    on_we         = 1'b0;
    on_idx        = '0;
    emit          = 1'b0;

    // A taken result frees the output register.
    if (res_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty && (!res_valid_r || res_pop)) begin
          q_rd      = 1'b1;
          cmd_nxt   = q_item;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        emit = 1'b1;
        case (cmd_r.op)
          OP_NOTE_ON: begin
            if (any_free) begin
              on_we  = 1'b1;
              on_idx = free_idx;
            end else begin
              emit      = 1'b0;
              idx_nxt   = '0;
              svld_nxt  = 1'b0;
              best_nxt  = '1;
              bidx_nxt  = '0;
              state_nxt = ST_SCAN;
            end
          end
          OP_NOTE_OFF: begin
            if (ch_sustain >= LEVEL_W'(SUSTAIN_ON)) begin
              held_nxt = held_r | off_match;
            end else begin
              active_nxt           = active_r & ~off_match;
              res_nxt.key_off_mask = MASK_W'(off_match);
            end
          end
          OP_SUSTAIN: begin
            sustain_nxt[ch_idx] = cmd_r.value;
            if (cmd_r.value < LEVEL_W'(SUSTAIN_ON)) begin
              active_nxt           = active_r & ~rel_match;
              held_nxt             = held_r & ~rel_match;
              res_nxt.key_off_mask = MASK_W'(rel_match);
            end
          end
          OP_REVERB: begin
            chrev_nxt[ch_idx] = cmd_r.value;
          end
          OP_TICK: begin
            tick_nxt = tick_r + 1'b1;
          end
          OP_RESTART: begin
            active_nxt = '0;
            held_nxt   = '0;
            reverb_nxt = '0;
            tick_nxt   = '0;
            for (int c = 0; c < CHANNELS; c++) begin
              sustain_nxt[c] = '0;
              chrev_nxt[c]   = LEVEL_W'(REVERB_DEFAULT);
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        // Score one voice per cycle; compare the previous one.
        score_nxt = score_now;
        sidx_nxt  = idx_r;
        svld_nxt  = 1'b1;
        if (svld_r && ($signed(score_r) > $signed(best_r))) begin
          best_nxt = score_r;
          bidx_nxt = sidx_r;
        end
        if (scan_last) begin
          state_nxt = ST_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_LAST: begin
        emit   = 1'b1;
        on_we  = 1'b1;
        on_idx = steal_idx;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Every result clears its fields but a key-off mask set above; the rest is set below.
    if (emit) begin
      res_valid_nxt       = 1'b1;
      res_nxt.voice_valid = 1'b0;
      res_nxt.voice       = '0;
      res_nxt.stolen      = 1'b0;
      res_nxt.key_on_mask = '0;
      if (!((cmd_r.op == OP_NOTE_OFF) || (cmd_r.op == OP_SUSTAIN))) begin
        res_nxt.key_off_mask = '0;
      end else if (cmd_r.op == OP_NOTE_OFF && ch_sustain >= LEVEL_W'(SUSTAIN_ON)) begin
        res_nxt.key_off_mask = '0;
      end else if (cmd_r.op == OP_SUSTAIN && cmd_r.value >= LEVEL_W'(SUSTAIN_ON)) begin
        res_nxt.key_off_mask = '0;
      end
      state_nxt = ST_IDLE;
    end

    // Voice assignment for note on, from the free search or the steal scan.
    if (on_we) begin
      active_nxt[on_idx]   = 1'b1;
      held_nxt[on_idx]     = 1'b0;
      reverb_nxt[on_idx]   = (ch_reverb != '0);
      res_nxt.voice_valid  = 1'b1;
      res_nxt.voice        = VOICE_W'(on_idx);
      res_nxt.stolen       = active_r[on_idx];
      res_nxt.key_on_mask  = MASK_W'(VOICES'(1) << on_idx);
      res_nxt.key_off_mask = active_r[on_idx] ? MASK_W'(VOICES'(1) << on_idx) : '0;
    end

    if (emit) begin
      res_nxt.reverb_mask = MASK_W'(reverb_nxt);
    end
  end

  // State and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      held_r      <= '0;
      reverb_r    <= '0;
      tick_r      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sustain_r[c] <= '0;
        chrev_r[c]   <= LEVEL_W'(REVERB_DEFAULT);
      end
      svld_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      held_r      <= held_nxt;
      reverb_r    <= reverb_nxt;
      tick_r      <= tick_nxt;
      sustain_r   <= sustain_nxt;
      chrev_r     <= chrev_nxt;
      svld_r      <= svld_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    score_r <= score_nxt;
    sidx_r  <= sidx_nxt;
    best_r  <= best_nxt;
    bidx_r  <= bidx_nxt;
    res_r   <= res_nxt;
  end

  // Note data of the voice being assigned.
  always_ff @(posedge clk) begin
    if (on_we) begin
      vchan_r[on_idx]  <= cmd_r.channel;
      vnote_r[on_idx]  <= cmd_r.note;
      vvel_r[on_idx]   <= cmd_r.velocity;
      vstart_r[on_idx] <= tick_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[rtl/synth_voice_allocator.sv]
// A word reaches the result side through the command queue and the engine's idle and execute
//   states; a note on that must steal also passes a scan over the clamped voice count and a last state.
// The engine takes no new word before it is through with the last one and its result is popped;
//   a stealing note on scores one voice per cycle through a single adder chain.
// Reset (synchronous, rst_n low): queues empty, all voices free and released,
//   sustain 0 and reverb 40 on every channel, tick count 0, voice count 16.
// ----------------------------------------------------------------------------
// Synthesizer voice allocator
// Top level: configuration register, front end, command queue and engine.
// ----------------------------------------------------------------------------
module synth_voice_allocator #(
  parameter int VOICES   = sva_pkg::VOICES_DEFAULT,
  parameter int CHANNELS = sva_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sva_pkg::COUNT_W-1:0]   cfg_voice_count,
  // Input word channel.
  input  logic                          push,
  output logic                          full,
  input  logic [sva_pkg::CMD_W-1:0]     in_command,
  input  logic [sva_pkg::CHAN_W-1:0]    in_channel,
  input  logic [sva_pkg::NOTE_W-1:0]    in_note,
  input  logic [sva_pkg::NOTE_W-1:0]    in_velocity,
  input  logic [sva_pkg::LEVEL_W-1:0]   in_value,
  input  logic                          in_tone_valid,
  // Result word channel.
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_voice_valid,
  output logic [sva_pkg::VOICE_W-1:0]   out_voice,
  output logic                          out_stolen,
  output logic [sva_pkg::MASK_W-1:0]    out_key_on_mask,
  output logic [sva_pkg::MASK_W-1:0]    out_key_off_mask,
  output logic [sva_pkg::MASK_W-1:0]    out_reverb_mask
);
  import sva_pkg::*;

  logic [COUNT_W-1:0] voice_count_r;
  logic               q_full;
  logic               q_empty;
  logic               q_wr;
  logic               q_rd;
  cmd_item_t          q_wr_item;
  cmd_item_t          q_rd_item;
  logic               res_valid;
  result_t            res;

  // Voice count register; writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_count_r <= VOICE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      voice_count_r <= cfg_voice_count;
    end
  end

  // Decode incoming words.
  sva_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_channel    (in_channel),
    .in_note       (in_note),
    .in_velocity   (in_velocity),
    .in_value      (in_value),
    .in_tone_valid (in_tone_valid),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_item        (q_wr_item)
  );

  // Decouple the decoder from the engine.
  sva_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rd_item (q_rd_item)
  );

  // Voice state and command execution.
  sva_engine #(
    .VOICES   (VOICES),
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .voice_count (voice_count_r),
    .q_empty     (q_empty),
    .q_item      (q_rd_item),
    .q_rd        (q_rd),
    .res_pop     (pop),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result word on the output ports.
  assign empty            = !res_valid;
  assign out_voice_valid  = res.voice_valid;
  assign out_voice        = res.voice;
  assign out_stolen       = res.stolen;
  assign out_key_on_mask  = res.key_on_mask;
  assign out_key_off_mask = res.key_off_mask;
  assign out_reverb_mask  = res.reverb_mask;

endmodule
